FILE: rtl/ptir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptir_pkg
// Types, constants and register codes shared by the timestamp index recorder.
// ----------------------------------------------------------------------------
package ptir_pkg;

  localparam int unsigned PtsW      = 64;
  localparam int unsigned OffsetW   = 48;
  localparam int unsigned CfgW      = 31;
  localparam int unsigned DiffW     = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  localparam logic [CfgW-1:0] MaxStepReset        = 31'd10000;
  localparam logic [CfgW-1:0] RecordIntervalReset = 31'd300;

  typedef enum logic [0:0] {
    CFG_MAX_STEP        = 1'b0,
    CFG_RECORD_INTERVAL = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic               req_type;
    logic [PtsW-1:0]    pts;
    logic [OffsetW-1:0] byte_offset;
  } in_req_t;

  typedef struct packed {
    logic [PtsW-1:0]    entry_time;
    logic [OffsetW-1:0] entry_offset;
  } out_entry_t;

  // classified request passed from front to back
  typedef struct packed {
    logic               first;
    logic               jump;
    logic               forced;
    logic [CfgW-1:0]    step;
    logic [DiffW-1:0]   pts_lo;
    logic [OffsetW-1:0] byte_offset;
  } cls_req_t;

endpackage

FILE: rtl/pts_time_index_recorder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_time_index_recorder
// Builds continuous-time index entries from timestamp and byte offset requests.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the queue has room. The front classifies
// each request against the previous timestamp and pushes it into a two-entry
// queue; the back updates the running time, gates on the record interval and
// places an entry in a single output register, fed from the queue. Sustained
// throughput is one request per cycle as long as entries are taken; the back
// stalls only when the output register is full. Requests that produce no
// entry leave no output. Configuration writes are taken at any time but must
// only be issued while the block is idle.
// ----------------------------------------------------------------------------
module pts_time_index_recorder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ptir_pkg::in_req_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ptir_pkg::out_entry_t       out_data,
  input  logic                       cfg_we,
  input  ptir_pkg::cfg_index_t       cfg_index,
  input  logic [ptir_pkg::CfgW-1:0]  cfg_data
);

  logic [ptir_pkg::CfgW-1:0]  max_step;
  logic [ptir_pkg::CfgW-1:0]  record_interval;
  logic                       push;
  ptir_pkg::cls_req_t         push_data;
  logic                       q_full;
  logic                       pop;
  logic                       q_valid;
  ptir_pkg::cls_req_t         q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step        <= ptir_pkg::MaxStepReset;
      record_interval <= ptir_pkg::RecordIntervalReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptir_pkg::CFG_MAX_STEP:        max_step        <= cfg_data;
        ptir_pkg::CFG_RECORD_INTERVAL: record_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  ptir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .max_step  (max_step),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  ptir_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  ptir_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .pop             (pop),
    .record_interval (record_interval),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule

FILE: rtl/ptir_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptir_front
// Accepts requests, tracks the previous timestamp and classifies each step
// as first, jump or continuous.
// ----------------------------------------------------------------------------
module ptir_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  ptir_pkg::in_req_t          in_data,
  input  logic [ptir_pkg::CfgW-1:0]  max_step,
  output logic                       push,
  output ptir_pkg::cls_req_t         push_data,
  input  logic                       q_full
);

  logic                        started;
  logic [ptir_pkg::DiffW-1:0]  prev_pts;
  logic [ptir_pkg::DiffW-1:0]  diff;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // only the low 32 bits of the step matter
  assign diff = in_data.pts[ptir_pkg::DiffW-1:0] - prev_pts;

  always_comb begin
    push_data.first       = !started;
    push_data.jump        = diff[ptir_pkg::DiffW-1] ||
                            (diff[ptir_pkg::CfgW-1:0] > max_step);
    push_data.forced      = in_data.req_type;
    push_data.step        = diff[ptir_pkg::CfgW-1:0];
    push_data.pts_lo      = in_data.pts[ptir_pkg::DiffW-1:0];
    push_data.byte_offset = in_data.byte_offset;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      prev_pts <= '0;
    end else if (push) begin
      started  <= 1'b1;
      prev_pts <= in_data.pts[ptir_pkg::DiffW-1:0];
    end
  end

endmodule

FILE: rtl/ptir_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptir_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module ptir_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ptir_pkg::cls_req_t  push_data,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output ptir_pkg::cls_req_t  q_data
);

  ptir_pkg::cls_req_t               entries [ptir_pkg::QueueDepth];
  logic [ptir_pkg::QPtrW-1:0]       wr_ptr;
  logic [ptir_pkg::QPtrW-1:0]       rd_ptr;
  logic [ptir_pkg::QCntW-1:0]       count;

  assign full    = (count == ptir_pkg::QCntW'(ptir_pkg::QueueDepth));
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == ptir_pkg::QPtrW'(ptir_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == ptir_pkg::QPtrW'(ptir_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/ptir_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptir_back
// Advances the running time, applies the record interval gate and holds
// the outgoing index entry.
// ----------------------------------------------------------------------------
module ptir_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  ptir_pkg::cls_req_t         q_data,
  output logic                       pop,
  input  logic [ptir_pkg::CfgW-1:0]  record_interval,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ptir_pkg::out_entry_t       out_data
);

  logic [ptir_pkg::PtsW-1:0]   running_time;
  logic [ptir_pkg::PtsW-1:0]   running_time_next;
  logic [ptir_pkg::DiffW-1:0]  rec_pts_lo;
  logic                        record_valid;
  logic [ptir_pkg::DiffW-1:0]  gap;
  logic                        have;
  logic                        emit;
  logic                        rebase;

  assign pop = q_valid && (!out_valid || out_ready);
  assign gap = q_data.pts_lo - rec_pts_lo;

  always_comb begin
    running_time_next = running_time;
    have              = 1'b1;
    rebase            = 1'b0;
    if (q_data.first) begin
      running_time_next = '0;
    end else if (q_data.jump) begin
      if (!q_data.forced) begin
        have   = 1'b0;
        rebase = 1'b1;
      end
    end else begin
      running_time_next = running_time + ptir_pkg::PtsW'(q_data.step);
    end
    if (q_data.forced) begin
      emit = have;
    end else begin
      emit = have && (!record_valid ||
             (!gap[ptir_pkg::DiffW-1] && (gap[ptir_pkg::CfgW-1:0] > record_interval)));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_time <= '0;
      rec_pts_lo   <= '0;
      record_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        running_time <= running_time_next;
        if (emit || rebase) begin
          rec_pts_lo   <= q_data.pts_lo;
          record_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data.entry_time   <= running_time_next;
      out_data.entry_offset <= q_data.byte_offset;
    end
  end

endmodule

FILE: dv/pts_time_index_recorder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_time_index_recorder_tb
// Self-checking bench for the timestamp index recorder.
// ----------------------------------------------------------------------------
// A directed table covers the first request, interval and step boundaries,
// backward and forward jumps in both modes, timestamp wrap and the all-ones
// timestamp. Random phases follow, each under its own register setting and
// handshake pressure. Every accepted request runs through a local model of
// the index logic; entries are compared field by field in order.
// ----------------------------------------------------------------------------
module pts_time_index_recorder_tb;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 48;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned DIR_N        = 19;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ENTRY} chk_kind_t;

  typedef struct packed {
    logic                         req_type;
    logic [ptir_pkg::PtsW-1:0]    pts;
    logic [ptir_pkg::OffsetW-1:0] off;
    chk_kind_t                    kind;
    logic [ptir_pkg::PtsW-1:0]    t;
  } dir_row_t;

  typedef struct packed {
    chk_kind_t            kind;
    ptir_pkg::out_entry_t ent;
  } req_check_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  ptir_pkg::in_req_t         in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  ptir_pkg::out_entry_t      out_data;
  logic                      cfg_we = 1'b0;
  ptir_pkg::cfg_index_t      cfg_index = ptir_pkg::CFG_MAX_STEP;
  logic [ptir_pkg::CfgW-1:0] cfg_data = '0;

  // model state
  logic [ptir_pkg::CfgW-1:0] cfg_max_step = ptir_pkg::MaxStepReset;
  logic [ptir_pkg::CfgW-1:0] cfg_interval = ptir_pkg::RecordIntervalReset;
  logic                      seen_first = 1'b0;
  logic [ptir_pkg::PtsW-1:0] prev_ts = '0;
  logic                      rec_valid = 1'b0;
  logic [ptir_pkg::PtsW-1:0] rec_pts = '0;
  logic [ptir_pkg::PtsW-1:0] run_time = '0;

  ptir_pkg::out_entry_t entry_q[$];
  req_check_t check_q[$];
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [ptir_pkg::PtsW-1:0]    gen_pts;
  logic [ptir_pkg::OffsetW-1:0] gen_off;

  // first request, interval boundary, step boundary, jumps, wrap, all ones
  dir_row_t dir_tab [DIR_N] = '{
    '{1'b0, 64'd1000, 48'd0, CHK_ENTRY, 64'd0},
    '{1'b0, 64'd1100, 48'd1, CHK_NONE, 64'd0},
    '{1'b0, 64'd1300, 48'd2, CHK_NONE, 64'd0},
    '{1'b0, 64'd1301, 48'd3, CHK_MODEL, 64'd0},
    '{1'b1, 64'd1301, 48'd4, CHK_MODEL, 64'd0},
    '{1'b0, 64'd500, 48'd5, CHK_NONE, 64'd0},
    '{1'b1, 64'd400, 48'd6, CHK_MODEL, 64'd0},
    '{1'b0, 64'd10400, 48'd7, CHK_MODEL, 64'd0},
    '{1'b0, 64'd20401, 48'd8, CHK_NONE, 64'd0},
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, CHK_MODEL, 64'd0},
    '{1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 48'd0, CHK_MODEL, 64'd0},
    '{1'b0, 64'd2000, 48'd10, CHK_MODEL, 64'd0},
    '{1'b0, 64'h1_0000_07D0, 48'd11, CHK_MODEL, 64'd0},
    '{1'b0, 64'h1_8000_07D0, 48'd12, CHK_NONE, 64'd0},
    '{1'b0, 64'h2_0000_07CF, 48'd13, CHK_NONE, 64'd0},
    '{1'b1, 64'hA5A5_5A5A_0000_0000, 48'h5A5A_A5A5_5A5A, CHK_MODEL, 64'd0},
    '{1'b1, 64'h5A5A_A5A5_0000_0064, 48'hA5A5_5A5A_A5A5, CHK_MODEL, 64'd0},
    '{1'b0, 64'h8000_0000_0000_0000, 48'd14, CHK_NONE, 64'd0},
    '{1'b0, 64'd0, 48'd15, CHK_MODEL, 64'd0}
  };

  pts_time_index_recorder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // updates the index state for one request; returns 1 when an entry is due
  function automatic bit index_update(input ptir_pkg::in_req_t r,
                                      output ptir_pkg::out_entry_t e);
    logic [31:0] step;
    logic [31:0] gap;
    logic        have;
    logic        emit;
    step = r.pts[31:0] - prev_ts[31:0];
    have = 1'b0;
    if (!seen_first) begin
      run_time = '0;
      have = 1'b1;
    end else if (step[31] || (step[30:0] > cfg_max_step)) begin
      if (r.req_type) begin
        have = 1'b1;
      end else begin
        rec_pts = r.pts;
        rec_valid = 1'b1;
      end
    end else begin
      run_time = run_time + {32'd0, step};
      have = 1'b1;
    end
    if (r.req_type) begin
      emit = have;
    end else begin
      gap = r.pts[31:0] - rec_pts[31:0];
      emit = have && (!rec_valid || (!gap[31] && (gap[30:0] > cfg_interval)));
    end
    e.entry_time = run_time;
    e.entry_offset = r.byte_offset;
    if (emit) begin
      rec_pts = r.pts;
      rec_valid = 1'b1;
    end
    prev_ts = r.pts;
    seen_first = 1'b1;
    return emit;
  endfunction

  always @(posedge clk) begin : accept_mon
    req_check_t           c;
    ptir_pkg::out_entry_t e;
    bit                   hit;
    if (!rst && in_valid && in_ready) begin
      c = check_q.pop_front();
      hit = index_update(in_data, e);
      if (c.kind == CHK_MODEL && hit) entry_q.push_back(e);
      else if (c.kind == CHK_ENTRY) entry_q.push_back(c.ent);
    end
  end

  always @(posedge clk) begin : entry_mon
    ptir_pkg::out_entry_t e;
    if (!rst && out_valid && out_ready) begin
      if (entry_q.size() == 0) begin
        $error("unexpected entry: entry_time %h entry_offset %h",
               out_data.entry_time, out_data.entry_offset);
        fail_count++;
      end else begin
        e = entry_q.pop_front();
        if (out_data.entry_time !== e.entry_time) begin
          $error("entry_time expected %h got %h", e.entry_time, out_data.entry_time);
          fail_count++;
        end
        if (out_data.entry_offset !== e.entry_offset) begin
          $error("entry_offset expected %h got %h", e.entry_offset,
                 out_data.entry_offset);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  task automatic send_req(input ptir_pkg::in_req_t r, input req_check_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    check_q.push_back(c);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    while (entry_q.size() != 0 || check_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input ptir_pkg::cfg_index_t idx,
                           input logic [ptir_pkg::CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == ptir_pkg::CFG_MAX_STEP) cfg_max_step = val;
    else cfg_interval = val;
  endtask

  // mostly continuous steps from the last timestamp, some boundaries and jumps
  function automatic ptir_pkg::in_req_t make_req();
    ptir_pkg::in_req_t r;
    int unsigned       sel;
    int unsigned       lim;
    sel = $urandom_range(0, 9);
    lim = (cfg_max_step > 20000) ? 20000 : cfg_max_step + cfg_max_step / 8 + 2;
    case (sel)
      0, 1, 2, 3, 4: gen_pts = gen_pts + $urandom_range(0, lim);
      5: gen_pts = gen_pts + cfg_interval + $urandom_range(0, 1);
      6: gen_pts = gen_pts + cfg_max_step + $urandom_range(0, 1);
      7: gen_pts = gen_pts - $urandom_range(1, 1000);
      8: gen_pts = {$urandom, $urandom};
      default: gen_pts = gen_pts + {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 9) == 0) gen_off = ptir_pkg::OffsetW'({$urandom, $urandom});
    else gen_off = gen_off + $urandom_range(0, 4000);
    r.req_type = ($urandom_range(0, 3) == 0);
    r.pts = gen_pts;
    r.byte_offset = gen_off;
    return r;
  endfunction

  task automatic set_pressure(input int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
      default: begin send_idle_pct = 30; recv_stall_pct = 30; end
    endcase
  endtask

  initial begin
    ptir_pkg::in_req_t         r;
    req_check_t                c;
    logic [ptir_pkg::CfgW-1:0] ms;
    logic [ptir_pkg::CfgW-1:0] ri;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_pressure(0);
    for (int i = 0; i < DIR_N; i++) begin
      r.req_type = dir_tab[i].req_type;
      r.pts = dir_tab[i].pts;
      r.byte_offset = dir_tab[i].off;
      c.kind = dir_tab[i].kind;
      c.ent.entry_time = dir_tab[i].t;
      c.ent.entry_offset = dir_tab[i].off;
      send_req(r, c);
    end
    in_valid <= 1'b0;
    gen_pts = dir_tab[DIR_N-1].pts;
    gen_off = '0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin ms = '0;           ri = '0;           end
        1: begin ms = 31'h7FFF_FFFF; ri = 31'h7FFF_FFFF; end
        2: begin ms = 31'd1000;     ri = 31'd50;       end
        3: begin ms = 31'h7FFF_FFFF; ri = '0;           end
        4: begin ms = '0;           ri = 31'h7FFF_FFFF; end
        5: begin
          ms = ptir_pkg::CfgW'($urandom_range(1, 20000));
          ri = ptir_pkg::CfgW'($urandom_range(0, 2000));
        end
        6: begin ms = ptir_pkg::MaxStepReset; ri = ptir_pkg::RecordIntervalReset; end
        default: begin
          ms = ptir_pkg::CfgW'($urandom);
          ri = ptir_pkg::CfgW'($urandom);
        end
      endcase
      drain();
      write_cfg(ptir_pkg::CFG_MAX_STEP, ms);
      write_cfg(ptir_pkg::CFG_RECORD_INTERVAL, ri);
      cfg_we <= 1'b0;
      set_pressure(p);
      c.kind = CHK_MODEL;
      c.ent = '0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_req(make_req(), c);
      end
      in_valid <= 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
